[hw/rtl/tdb_pkg.sv]
// Shared types and constants for the control transfer descriptor builder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tdb_pkg;

  localparam int unsigned LenW  = 16;
  localparam int unsigned MpW   = 11;
  localparam int unsigned AddrW = 64;
  localparam int unsigned TokW  = 32;

  localparam logic [1:0] PidOut   = 2'd0;
  localparam logic [1:0] PidIn    = 2'd1;
  localparam logic [1:0] PidSetup = 2'd2;

  localparam logic [1:0] StageSetup  = 2'd0;
  localparam logic [1:0] StageData   = 2'd1;
  localparam logic [1:0] StageStatus = 2'd2;

  localparam logic [1:0]    TokCerr    = 2'd3;
  localparam logic [MpW-1:0] SetupBytes = MpW'(8);

  typedef struct packed {
    logic             err;
    logic             dir_in;
    logic [LenW-1:0]  len;
    logic [MpW-1:0]   mp;
    logic [AddrW-1:0] setup_addr;
    logic [AddrW-1:0] data_addr;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StData   = 3'b010,
    StStatus = 3'b100
  } back_state_e;

  function automatic logic [TokW-1:0] make_token(logic toggle, logic [MpW-1:0] length,
                                                 logic [1:0] pid);
    logic [TokW-1:0] tok;
    tok        = '0;
    tok[31]    = toggle;
    tok[30:16] = 15'(length);
    tok[11:10] = TokCerr;
    tok[9:8]   = pid;
    tok[7]     = 1'b1;
    return tok;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/tdb_front.sv]
// Front end: accepts requests, checks them against the descriptor pool
// and keeps them in a two-entry queue. Depends on tdb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tdb_front #(
  parameter int unsigned DESCRIPTOR_COUNT = 32
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       start,
  output logic                      busy,
  input  wire                       device_to_host_i,
  input  wire [tdb_pkg::LenW-1:0]   data_length_i,
  input  wire [tdb_pkg::MpW-1:0]    max_packet_i,
  input  wire [tdb_pkg::AddrW-1:0]  setup_address_i,
  input  wire [tdb_pkg::AddrW-1:0]  data_address_i,
  input  wire                       pop_i,
  output tdb_pkg::queue_head_t      head_o
);
  import tdb_pkg::*;

  localparam int unsigned Limit = DESCRIPTOR_COUNT - 2;
  localparam int unsigned ProdW = MpW + $clog2(DESCRIPTOR_COUNT);
  localparam int unsigned CmpW  = (ProdW > LenW) ? ProdW : LenW;

  cmd_t             mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic [MpW-1:0]   mp_norm;
  logic [CmpW-1:0]  limit_bytes;
  cmd_t             cmd_new;
  logic             push;

  assign mp_norm     = (max_packet_i == '0) ? MpW'(1) : max_packet_i;
  assign limit_bytes = CmpW'(mp_norm) * CmpW'(Limit);

  always_comb begin
    cmd_new.err        = CmpW'(data_length_i) > limit_bytes;
    cmd_new.dir_in     = device_to_host_i;
    cmd_new.len        = data_length_i;
    cmd_new.mp         = mp_norm;
    cmd_new.setup_addr = setup_address_i;
    cmd_new.data_addr  = data_address_i;
  end

  assign busy  = count_q == 2'd2;
  assign push  = start && !busy;

  assign head_o.valid = count_q != 2'd0;
  assign head_o.cmd   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ (pop_i && head_o.valid);
    count_d  = count_q + 2'(push) - 2'(pop_i && head_o.valid);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/tdb_back.sv]
// Back end: walks one request and drives one descriptor word per cycle
// from registered outputs. Depends on tdb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tdb_back (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  tdb_pkg::queue_head_t      head_i,
  output logic                      pop_o,
  output logic                      result_valid_o,
  output logic [tdb_pkg::TokW-1:0]  token_word_o,
  output logic [tdb_pkg::AddrW-1:0] buffer_start_o,
  output logic [tdb_pkg::AddrW-1:0] page_one_o,
  output logic [tdb_pkg::AddrW-1:0] page_two_o,
  output logic [tdb_pkg::AddrW-1:0] page_three_o,
  output logic [1:0]                stage_o,
  output logic                      last_descriptor_o,
  output logic                      too_many_o
);
  import tdb_pkg::*;

  back_state_e      state_q, state_d;
  logic [LenW-1:0]  rem_q, rem_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [MpW-1:0]   mp_q, mp_d;
  logic             toggle_q, toggle_d;
  logic             dir_q, dir_d;

  logic             emit;
  logic             err;
  logic             tog;
  logic [MpW-1:0]   olen;
  logic [1:0]       pid;
  logic [AddrW-1:0] oaddr;
  logic [1:0]       stg;
  logic             last;
  logic [MpW-1:0]   piece;
  logic [51:0]      base;

  assign piece = (rem_q < LenW'(mp_q)) ? MpW'(rem_q) : mp_q;

  always_comb begin
    state_d  = state_q;
    rem_d    = rem_q;
    addr_d   = addr_q;
    mp_d     = mp_q;
    toggle_d = toggle_q;
    dir_d    = dir_q;
    pop_o    = 1'b0;
    emit     = 1'b0;
    err      = 1'b0;
    tog      = 1'b0;
    olen     = '0;
    pid      = PidOut;
    oaddr    = '0;
    stg      = StageSetup;
    last     = 1'b0;
    case (state_q)
      StIdle: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          emit  = 1'b1;
          if (head_i.cmd.err) begin
            err  = 1'b1;
            last = 1'b1;
          end else begin
            olen     = SetupBytes;
            pid      = PidSetup;
            oaddr    = head_i.cmd.setup_addr;
            rem_d    = head_i.cmd.len;
            addr_d   = head_i.cmd.data_addr;
            mp_d     = head_i.cmd.mp;
            dir_d    = head_i.cmd.dir_in;
            toggle_d = 1'b1;
            state_d  = (head_i.cmd.len == '0) ? StStatus : StData;
          end
        end
      end
      StData: begin
        emit     = 1'b1;
        tog      = toggle_q;
        olen     = piece;
        pid      = dir_q ? PidIn : PidOut;
        oaddr    = addr_q;
        stg      = StageData;
        toggle_d = !toggle_q;
        rem_d    = rem_q - LenW'(piece);
        addr_d   = addr_q + AddrW'(piece);
        if (rem_q == LenW'(piece)) begin
          state_d = StStatus;
        end
      end
      StStatus: begin
        emit    = 1'b1;
        tog     = 1'b1;
        pid     = dir_q ? PidOut : PidIn;
        stg     = StageStatus;
        last    = 1'b1;
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign base = oaddr[63:12];

  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (err) begin
        token_word_o   <= '0;
        buffer_start_o <= '0;
        page_one_o     <= '0;
        page_two_o     <= '0;
        page_three_o   <= '0;
      end else begin
        token_word_o   <= make_token(tog, olen, pid);
        buffer_start_o <= oaddr;
        page_one_o     <= {base + 52'd1, 12'h000};
        page_two_o     <= {base + 52'd2, 12'h000};
        page_three_o   <= {base + 52'd3, 12'h000};
      end
      stage_o           <= stg;
      last_descriptor_o <= last;
      too_many_o        <= err;
    end
    rem_q    <= rem_d;
    addr_q   <= addr_d;
    mp_q     <= mp_d;
    toggle_q <= toggle_d;
    dir_q    <= dir_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_o <= emit;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/usb_control_transfer_td_builder_top.sv]
// Top level of the control transfer descriptor builder: front queue and back walker.
// Depends on tdb_pkg, tdb_front and tdb_back.
// A request of n data pieces gives n + 2 words on consecutive cycles; it passes the queue
// and, when the back end is idle, the output registers; an overflow gives one word.
// The back end starts the next queued request right after a status or overflow word, so
// queued requests follow without a gap; busy rises only when the two-entry queue is full.
// Reset is asynchronous and active low; it empties the queue and drops the strobe.
`timescale 1ns / 1ps
`default_nettype none
module usb_control_transfer_td_builder_top #(
  parameter int unsigned DESCRIPTOR_COUNT = 32
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       start,
  output logic                      busy,
  input  wire                       device_to_host_i,
  input  wire [tdb_pkg::LenW-1:0]   data_length_i,
  input  wire [tdb_pkg::MpW-1:0]    max_packet_i,
  input  wire [tdb_pkg::AddrW-1:0]  setup_address_i,
  input  wire [tdb_pkg::AddrW-1:0]  data_address_i,
  output logic                      result_valid_o,
  output logic [tdb_pkg::TokW-1:0]  token_word_o,
  output logic [tdb_pkg::AddrW-1:0] buffer_start_o,
  output logic [tdb_pkg::AddrW-1:0] page_one_o,
  output logic [tdb_pkg::AddrW-1:0] page_two_o,
  output logic [tdb_pkg::AddrW-1:0] page_three_o,
  output logic [1:0]                stage_o,
  output logic                      last_descriptor_o,
  output logic                      too_many_o
);
  import tdb_pkg::*;

  queue_head_t head;
  logic        pop;

  tdb_front #(
    .DESCRIPTOR_COUNT(DESCRIPTOR_COUNT)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .device_to_host_i (device_to_host_i),
    .data_length_i    (data_length_i),
    .max_packet_i     (max_packet_i),
    .setup_address_i  (setup_address_i),
    .data_address_i   (data_address_i),
    .pop_i            (pop),
    .head_o           (head)
  );

  tdb_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_i            (head),
    .pop_o             (pop),
    .result_valid_o    (result_valid_o),
    .token_word_o      (token_word_o),
    .buffer_start_o    (buffer_start_o),
    .page_one_o        (page_one_o),
    .page_two_o        (page_two_o),
    .page_three_o      (page_three_o),
    .stage_o           (stage_o),
    .last_descriptor_o (last_descriptor_o),
    .too_many_o        (too_many_o)
  );

endmodule
`default_nettype wire

[hw/rtl/tdb_checker.sv]
// Port-level checker for the descriptor builder and its bind to the top level.
// Depends on tdb_pkg and usb_control_transfer_td_builder_top.
`timescale 1ns / 1ps
`default_nettype none
module tdb_checker (
  input wire                       clk_i,
  input wire                       rst_ni,
  input wire                       result_valid_o,
  input wire [tdb_pkg::TokW-1:0]   token_word_o,
  input wire [1:0]                 stage_o,
  input wire                       last_descriptor_o,
  input wire                       too_many_o
);
  import tdb_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && too_many_o |-> last_descriptor_o && token_word_o == '0)
    else $error("Overflow word is not a lone zero word.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !too_many_o |-> (stage_o == StageStatus) == last_descriptor_o)
    else $error("Last word is not the status descriptor.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !too_many_o && stage_o == StageSetup |=>
      result_valid_o && (stage_o == StageData || stage_o == StageStatus))
    else $error("Setup descriptor not followed by the rest of its chain.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !too_many_o && stage_o == StageData |=>
      result_valid_o && (stage_o == StageData || stage_o == StageStatus))
    else $error("Data descriptor chain broken.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !too_many_o && stage_o == StageData && token_word_o[31] |=>
      stage_o == StageStatus || !token_word_o[31])
    else $error("Data toggle did not alternate.");

endmodule

bind usb_control_transfer_td_builder_top tdb_checker u_tdb_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .result_valid_o    (result_valid_o),
  .token_word_o      (token_word_o),
  .stage_o           (stage_o),
  .last_descriptor_o (last_descriptor_o),
  .too_many_o        (too_many_o)
);
`default_nettype wire
